[sv/fsa_pkg.sv]
// Shared types and constants of the frame summing accumulator.
package fsa_pkg;

    localparam int MAX_PIXELS = 1048576;
    localparam int IDX_W      = $clog2(MAX_PIXELS);
    localparam int FRM_W      = 16;
    localparam int NF_W       = 17;
    localparam int NP_W       = 21;
    localparam int CFG_W      = 21;

    // Register indexes on the configuration channel.
    localparam logic [0:0] REG_FRAMES_PER_SUM   = 1'b0;
    localparam logic [0:0] REG_PIXELS_PER_FRAME = 1'b1;

    localparam logic [NF_W-1:0] NF_MIN       = NF_W'(2);
    localparam logic [NF_W-1:0] NF_MAX       = NF_W'(65536);
    localparam logic [NF_W-1:0] NF_RESET     = NF_W'(2);
    localparam logic [NP_W-1:0] NP_MAX       = NP_W'(MAX_PIXELS);
    localparam logic [NP_W-1:0] NP_RESET     = NP_W'(1048576);

    // Input thresholds and sticky codes.
    localparam logic signed [15:0] UNDER_IN   = -16'sd32765;
    localparam logic signed [15:0] OVER_IN    = 16'sd32764;
    localparam logic [31:0]        CODE_UNDER = 32'h8000_0000;
    localparam logic [31:0]        CODE_OVER  = 32'h7FFF_FFFF;
    localparam logic signed [32:0] SUM_MAX    = 33'sh0_7FFF_FFFF;
    localparam logic signed [32:0] SUM_MIN    = 33'sh1_8000_0000;

    // Position of the pixel being accepted, as seen by the datapath.
    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic             first_frame;
        logic             last_frame;
        logic             last_pixel;
    } pix_pos_t;

    // One result word waiting on the output channel.
    typedef struct packed {
        logic [31:0] pixel_sum;
        logic        frame_last;
    } out_word_t;

endpackage

[sv/fsa_frame_ctrl.sv]
// Configuration registers and pixel/frame position counters.
module fsa_frame_ctrl
    import fsa_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_valid,
    input  logic [0:0]       cfg_index,
    input  logic [CFG_W-1:0] cfg_data,
    input  logic             advance,
    output pix_pos_t         pos
);

    logic [NF_W-1:0]  frames_per_sum_reg;
    logic [NP_W-1:0]  pixels_per_frame_reg;
    logic [IDX_W-1:0] pixel_index_reg, pixel_index_next;
    logic [FRM_W-1:0] frame_index_reg, frame_index_next;
    logic [NF_W-1:0]  nf_eff, frame_plus;
    logic [NP_W-1:0]  np_eff, pixel_plus;

    // Out-of-range settings are clamped to the nearest legal value.
    always_comb begin
        if (frames_per_sum_reg < NF_MIN) begin
            nf_eff = NF_MIN;
        end else if (frames_per_sum_reg > NF_MAX) begin
            nf_eff = NF_MAX;
        end else begin
            nf_eff = frames_per_sum_reg;
        end
        if (pixels_per_frame_reg == '0) begin
            np_eff = NP_W'(1);
        end else if (pixels_per_frame_reg > NP_MAX) begin
            np_eff = NP_MAX;
        end else begin
            np_eff = pixels_per_frame_reg;
        end
    end

    assign frame_plus = {1'b0, frame_index_reg} + NF_W'(1);
    assign pixel_plus = NP_W'(pixel_index_reg) + NP_W'(1);

    assign pos.idx         = pixel_index_reg;
    assign pos.first_frame = (frame_index_reg == '0);
    assign pos.last_frame  = (frame_plus >= nf_eff);
    assign pos.last_pixel  = (pixel_plus >= np_eff);

    always_comb begin
        pixel_index_next = pixel_index_reg;
        frame_index_next = frame_index_reg;
        if (advance) begin
            if (pos.last_pixel) begin
                pixel_index_next = '0;
                frame_index_next = pos.last_frame ? '0 : frame_plus[FRM_W-1:0];
            end else begin
                pixel_index_next = pixel_plus[IDX_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frames_per_sum_reg   <= NF_RESET;
            pixels_per_frame_reg <= NP_RESET;
            pixel_index_reg      <= '0;
            frame_index_reg      <= '0;
        end else begin
            pixel_index_reg <= pixel_index_next;
            frame_index_reg <= frame_index_next;
            if (cfg_valid) begin
                unique case (cfg_index)
                    REG_FRAMES_PER_SUM:   frames_per_sum_reg   <= cfg_data[NF_W-1:0];
                    REG_PIXELS_PER_FRAME: pixels_per_frame_reg <= cfg_data[NP_W-1:0];
                    default: ;
                endcase
            end
        end
    end

endmodule

[sv/fsa_out_buf.sv]
// Two-word output buffer that decouples the pipeline from the result channel.
module fsa_out_buf
    import fsa_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push,
    input  out_word_t push_word,
    output logic      full,
    output logic      m_tvalid,
    input  logic      m_tready,
    output out_word_t head_word
);

    out_word_t  entry_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;
    logic       pop;

    assign m_tvalid  = (count_reg != 2'd0);
    assign full      = (count_reg == 2'd2);
    assign pop       = m_tvalid && m_tready;
    assign head_word = entry_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_word;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            unique case ({push, pop})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

[sv/frame_summing_accumulator_unit.sv]
// Top level of the frame summing accumulator: per-pixel sum store and update pipeline.
//
//   channel  | direction | handshake          | payload
//   ---------+-----------+--------------------+-------------------------------------
//   s_       | in        | s_tvalid/s_tready  | s_tdata[15:0] pixel_value (signed)
//   m_       | out       | m_tvalid/m_tready  | m_tdata[31:0] pixel_sum, m_tlast frame_last
//   cfg_     | in        | cfg_valid/cfg_ready| cfg_index (0 frames, 1 pixels), cfg_data
//
// One pixel word is taken per cycle while the pipeline is not held. A result leaves the
// third pipeline register and enters a two-word output buffer, which registers it for m_.
// The rate is set by the single read port and single write port of the sum store,
// each used once per pixel. aresetn is synchronous and active low; it clears the
// counters, the pipeline valid bits and the output buffer, but not the sum store,
// whose entries are only defined once the first frame of a group has written them.
// Both ready outputs stay low during reset, and the whole pipeline holds when a
// result must be pushed while the buffer is full.
module frame_summing_accumulator_unit
    import fsa_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    // Pixel input.
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [15:0]      s_tdata,   // [15:0] pixel_value
    // Summed output.
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [31:0]      m_tdata,   // [31:0] pixel_sum
    output logic             m_tlast,
    // Configuration writes.
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [0:0]       cfg_index,
    input  logic [CFG_W-1:0] cfg_data
);

    // The sum store: one 32-bit entry per pixel position.
    logic [31:0] store_mem [MAX_PIXELS];
    logic [31:0] rd_data_reg;

    pix_pos_t  pos;
    logic      en, accept, buf_full;
    out_word_t buf_head;
    out_word_t s3_word;

    // Stage 1: pixel with its position; store read data arrives alongside.
    logic                s1_valid_reg;
    logic [IDX_W-1:0]    s1_idx_reg;
    logic signed [15:0]  s1_px_reg;
    logic                s1_first_reg, s1_lastf_reg, s1_lastp_reg;
    // Stage 2: raw 33-bit sum and sticky flags.
    logic                s2_valid_reg;
    logic [IDX_W-1:0]    s2_idx_reg;
    logic signed [32:0]  s2_sum_reg;
    logic                s2_under_reg, s2_over_reg, s2_lastf_reg, s2_lastp_reg;
    // Stage 3: final sum, already written back to the store.
    logic                s3_valid_reg;
    logic [IDX_W-1:0]    s3_idx_reg;
    logic [31:0]         s3_res_reg;
    logic                s3_lastf_reg, s3_lastp_reg;

    logic [31:0]         s1_old, s2_res;
    logic signed [32:0]  s1_sum;
    logic                s1_under, s1_over, s3_emit;

    assign cfg_ready = aresetn;

    // The pipeline moves as a whole unless a result is due and the buffer is full.
    assign s3_emit  = s3_valid_reg && s3_lastf_reg;
    assign en       = !(s3_emit && buf_full);
    assign s_tready = en && aresetn;
    assign accept   = s_tvalid && s_tready;

    fsa_frame_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .advance   (accept),
        .pos       (pos)
    );

    // The store read issued at acceptance misses the write made in the same cycle
    // and the one still pending in stage 2, so both are forwarded here, newest first.
    // The first frame of a group ignores the store and starts from zero.
    always_comb begin
        if (s1_first_reg) begin
            s1_old = '0;
        end else if (s2_valid_reg && (s2_idx_reg == s1_idx_reg)) begin
            s1_old = s2_res;
        end else if (s3_valid_reg && (s3_idx_reg == s1_idx_reg)) begin
            s1_old = s3_res_reg;
        end else begin
            s1_old = rd_data_reg;
        end
    end

    assign s1_sum   = $signed({s1_old[31], s1_old}) + $signed({{17{s1_px_reg[15]}}, s1_px_reg});
    assign s1_under = (s1_px_reg <= UNDER_IN) || (s1_old == CODE_UNDER);
    assign s1_over  = (s1_px_reg >= OVER_IN) || (s1_old == CODE_OVER);

    // Underload wins over overload; a sum running out of range saturates and sticks.
    always_comb begin
        priority if (s2_under_reg) begin
            s2_res = CODE_UNDER;
        end else if (s2_over_reg) begin
            s2_res = CODE_OVER;
        end else if (s2_sum_reg >= SUM_MAX) begin
            s2_res = CODE_OVER;
        end else if (s2_sum_reg <= SUM_MIN) begin
            s2_res = CODE_UNDER;
        end else begin
            s2_res = s2_sum_reg[31:0];
        end
    end

    // Store port: read at the accepted pixel's position, write back from stage 2.
    always_ff @(posedge aclk) begin
        if (en) begin
            rd_data_reg <= store_mem[pos.idx];
            if (s2_valid_reg) begin
                store_mem[s2_idx_reg] <= s2_res;
            end
        end
    end

    // Payload registers of the pipeline.
    always_ff @(posedge aclk) begin
        if (en) begin
            s1_idx_reg   <= pos.idx;
            s1_px_reg    <= $signed(s_tdata);
            s1_first_reg <= pos.first_frame;
            s1_lastf_reg <= pos.last_frame;
            s1_lastp_reg <= pos.last_pixel;

            s2_idx_reg   <= s1_idx_reg;
            s2_sum_reg   <= s1_sum;
            s2_under_reg <= s1_under;
            s2_over_reg  <= s1_over;
            s2_lastf_reg <= s1_lastf_reg;
            s2_lastp_reg <= s1_lastp_reg;

            s3_idx_reg   <= s2_idx_reg;
            s3_res_reg   <= s2_res;
            s3_lastf_reg <= s2_lastf_reg;
            s3_lastp_reg <= s2_lastp_reg;
        end
    end

    // Valid bits travel with the data.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end else if (en) begin
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    assign s3_word = '{pixel_sum: s3_res_reg, frame_last: s3_lastp_reg};

    // Only pixels of the last frame of a group leave the block.
    fsa_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (en && s3_emit),
        .push_word (s3_word),
        .full      (buf_full),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .head_word (buf_head)
    );

    assign m_tdata = buf_head.pixel_sum;
    assign m_tlast = buf_head.frame_last;

endmodule

[sv/fsa_checker.sv]
// Port-level checker of the frame summing accumulator and its binding.
module fsa_checker
    import fsa_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic        m_tlast,
    input logic        cfg_valid,
    input logic        cfg_ready
);

    // Reset empties the output buffer.
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result word present right after reset");

    // A word that waits holds its contents.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("waiting result word changed");

    // Input is refused only while finished results are backed up on the output.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("input stalled with no result waiting");

    // Configuration writes are never refused.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_valid |-> cfg_ready)
        else $error("configuration write refused");

endmodule

bind frame_summing_accumulator_unit fsa_checker u_fsa_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready)
);
